FILE: design/tsd_pkg.sv
// Shared types, constants and helpers for the terminator sequence deframer.
`default_nettype none
package tsd_pkg;

    // Terminator geometry
    localparam int MAX_DELIM_BYTES = 8;
    localparam int DELIM_W         = 8 * MAX_DELIM_BYTES;
    localparam int CNT_W           = 3;
    localparam int LEN_W           = 4;

    // Command queue depth
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_LENGTH = 1'b1;

    // What the back end has to do for one input byte
    typedef enum logic {
        CMD_DATA,
        CMD_END
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [CNT_W-1:0] replay_cnt;
        logic [7:0]       data_byte;
    } cmd_t;

    // Back end sequencer states
    typedef enum logic {
        BK_IDLE,
        BK_REPLAY
    } back_state_t;

    // Terminator byte at a given index
    function automatic logic [7:0] pattern_byte(input logic [DELIM_W-1:0] bytes,
                                                input logic [CNT_W-1:0]   idx);
        pattern_byte = bytes[{idx, 3'b000} +: 8];
    endfunction

endpackage
`default_nettype wire

FILE: design/tsd_front.sv
// Front end: accepts input bytes, tracks the terminator match and issues commands.
`default_nettype none
module tsd_front import tsd_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [DELIM_W-1:0] delim_bytes,
    input  wire logic [LEN_W-1:0]   delim_length,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_data_byte,
    output logic                    push,
    output cmd_t                    push_cmd,
    input  wire logic               queue_full
);

    logic [CNT_W-1:0] match_cnt_reg, match_cnt_next;
    logic [LEN_W-1:0] eff_len;
    logic             accept, hit, complete;

    // Clamp length to 1..MAX_DELIM_BYTES
    always_comb begin
        if (delim_length == '0) begin
            eff_len = LEN_W'(1);
        end else if (delim_length > LEN_W'(MAX_DELIM_BYTES)) begin
            eff_len = LEN_W'(MAX_DELIM_BYTES);
        end else begin
            eff_len = delim_length;
        end
    end

    assign s_ready  = !queue_full;
    assign accept   = s_valid && s_ready;
    assign hit      = (s_data_byte == pattern_byte(delim_bytes, match_cnt_reg));
    assign complete = ({1'b0, match_cnt_reg} + LEN_W'(1)) >= eff_len;

    // Classify the beat
    always_comb begin
        match_cnt_next      = match_cnt_reg;
        push                = 1'b0;
        push_cmd.kind       = CMD_DATA;
        push_cmd.replay_cnt = match_cnt_reg;
        push_cmd.data_byte  = s_data_byte;
        if (accept) begin
            if (!hit) begin
                push           = 1'b1;
                match_cnt_next = '0;
            end else if (!complete) begin
                match_cnt_next = match_cnt_reg + CNT_W'(1);
            end else begin
                push           = 1'b1;
                push_cmd.kind  = CMD_END;
                match_cnt_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_cnt_reg <= '0;
        end else begin
            match_cnt_reg <= match_cnt_next;
        end
    end

endmodule
`default_nettype wire

FILE: design/tsd_queue.sv
// Two-entry command queue between front and back ends.
`default_nettype none
module tsd_queue import tsd_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  cmd_t      push_cmd,
    output logic      full,
    input  wire logic pop,
    output cmd_t      pop_cmd,
    output logic      empty
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

FILE: design/tsd_back.sv
// Back end: replays held terminator bytes and drives the result register.
`default_nettype none
module tsd_back import tsd_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [DELIM_W-1:0] delim_bytes,
    input  wire logic               q_empty,
    input  cmd_t                    q_cmd,
    output logic                    q_pop,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [7:0]              m_out_byte,
    output logic                    m_message_end,
    output logic                    m_last
);

    back_state_t      state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg, byte_next;
    logic             end_reg, end_next;
    logic             last_reg, last_next;
    logic             adv;

    // Output slot is free when empty or being taken
    assign adv = !valid_reg || m_ready;

    // Sequencer
    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg && !m_ready;
        byte_next  = byte_reg;
        end_next   = end_reg;
        last_next  = last_reg;
        q_pop      = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (adv && !q_empty) begin
                    q_pop      = 1'b1;
                    valid_next = 1'b1;
                    cmd_next   = q_cmd;
                    if (q_cmd.kind == CMD_END) begin
                        byte_next = 8'h00;
                        end_next  = 1'b1;
                        last_next = 1'b1;
                    end else if (q_cmd.replay_cnt == '0) begin
                        byte_next = q_cmd.data_byte;
                        end_next  = 1'b0;
                        last_next = 1'b1;
                    end else begin
                        byte_next  = pattern_byte(delim_bytes, '0);
                        end_next   = 1'b0;
                        last_next  = 1'b0;
                        idx_next   = CNT_W'(1);
                        state_next = BK_REPLAY;
                    end
                end
            end
            BK_REPLAY: begin
                if (adv) begin
                    valid_next = 1'b1;
                    end_next   = 1'b0;
                    if (idx_reg == cmd_reg.replay_cnt) begin
                        byte_next  = cmd_reg.data_byte;
                        last_next  = 1'b1;
                        state_next = BK_IDLE;
                    end else begin
                        byte_next = pattern_byte(delim_bytes, idx_reg);
                        last_next = 1'b0;
                        idx_next  = idx_reg + CNT_W'(1);
                    end
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        idx_reg  <= idx_next;
        byte_reg <= byte_next;
        end_reg  <= end_next;
        last_reg <= last_next;
    end

    assign m_valid       = valid_reg;
    assign m_out_byte    = byte_reg;
    assign m_message_end = end_reg;
    assign m_last        = last_reg;

endmodule
`default_nettype wire

FILE: design/terminator_sequence_deframer_core.sv
// Top level of the terminator sequence deframer: config registers and wiring.
//
// Strips a programmable terminator of 1 to 8 bytes from a byte stream. A byte
// that matches the next terminator byte is held back and produces nothing; a
// mismatching byte produces the held-back prefix (replayed from the pattern)
// followed by the byte itself, the final beat flagged by m_last; a full match
// produces one beat with m_message_end set and m_out_byte zero. Input bytes
// are taken one per cycle while the two-entry command queue has room. The
// back end emits one result beat per cycle while m_ready is high, so a mismatch
// after k held bytes occupies it for k+1 beats and the input stalls once the
// queue fills. Results pass a queue entry, then the result register, to m_valid.
// Configuration is always ready and must only be written while the block is idle.
`default_nettype none
module terminator_sequence_deframer_core import tsd_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DELIM_W-1:0]   cfg_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [7:0]           s_data_byte,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [7:0]                m_out_byte,
    output logic                      m_message_end,
    output logic                      m_last
);

    logic [DELIM_W-1:0] delim_bytes_reg;
    logic [LEN_W-1:0]   delim_length_reg;
    logic               push, pop, q_full, q_empty;
    cmd_t               push_cmd, pop_cmd;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_bytes_reg  <= '0;
            delim_length_reg <= LEN_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_DELIM_BYTES:  delim_bytes_reg  <= cfg_data;
                REG_DELIM_LENGTH: delim_length_reg <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    tsd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .delim_bytes  (delim_bytes_reg),
        .delim_length (delim_length_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .push         (push),
        .push_cmd     (push_cmd),
        .queue_full   (q_full)
    );

    tsd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    tsd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .delim_bytes   (delim_bytes_reg),
        .q_empty       (q_empty),
        .q_cmd         (pop_cmd),
        .q_pop         (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_message_end (m_message_end),
        .m_last        (m_last)
    );

endmodule
`default_nettype wire

FILE: design/tsd_checker.sv
// Port-level checks for the terminator sequence deframer, bound to the top level.
`default_nettype none
module tsd_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_out_byte,
    input wire logic       m_message_end,
    input wire logic       m_last
);

    // Reset empties the result register
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte)
            && $stable(m_message_end) && $stable(m_last))
        else $error("stalled result beat changed");

    // End-of-message beat is a zero byte and closes the group
    a_end_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_message_end |-> m_out_byte == 8'h00 && m_last)
        else $error("malformed end-of-message beat");

    // Replay runs without gaps until the final beat
    a_replay_gapless: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid)
        else $error("gap inside a replayed group");

endmodule

bind terminator_sequence_deframer_core tsd_checker u_tsd_checker (.*);
`default_nettype wire
